FILE: rtl/core/tci_pkg.sv
package tci_pkg;

  // Command codes; code 7 is unused and leaves the state alone
  typedef enum logic [2:0] {
    ACT_PENUP    = 3'd0,
    ACT_PENDOWN  = 3'd1,
    ACT_COLOUR   = 3'd2,
    ACT_FORWARD  = 3'd3,
    ACT_BACKWARD = 3'd4,
    ACT_RIGHT    = 3'd5,
    ACT_LEFT     = 3'd6
  } action_t;

  // Four-way heading, clockwise order
  typedef enum logic [1:0] {
    HEAD_EAST  = 2'd0,
    HEAD_SOUTH = 2'd1,
    HEAD_WEST  = 2'd2,
    HEAD_NORTH = 2'd3
  } head_t;

  // Configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int          CANVAS_BITS  = 13;
  localparam logic [12:0] CANVAS_RESET = 13'd512;

  // Result kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_FINAL   = 1'b1;

  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // Push request from the command stage into the result queue
  typedef struct packed {
    logic push_one;
    logic push_two;
  } fifo_ctl_t;

  // Result queue room back to the command stage
  typedef struct packed {
    logic room2;
  } fifo_stat_t;

endpackage

FILE: rtl/core/tci_result_fifo.sv
module tci_result_fifo #(
  parameter int DATA_W = 58
) (
  input  logic                clk,
  input  logic                rst,
  input  tci_pkg::fifo_ctl_t  ctl,
  input  logic [DATA_W-1:0]   d0,
  input  logic [DATA_W-1:0]   d1,
  output tci_pkg::fifo_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DATA_W-1:0]   q
);

  localparam int DEPTH = 4;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [1:0]        rd_ptr;
  logic [1:0]        wr_ptr;
  logic [2:0]        count;
  logic [2:0]        count_next;
  logic [2:0]        n_push;
  logic [2:0]        count_after_pop;
  logic              pop;

  // Count what enters and leaves this cycle
  always_comb begin
    pop             = (count != 3'd0) && !out_stall;
    n_push          = ctl.push_two ? 3'd2 : (ctl.push_one ? 3'd1 : 3'd0);
    count_after_pop = count - {2'b00, pop};
    count_next      = count_after_pop + n_push;
  end

  assign stat.room2  = (count_after_pop <= 3'd2);
  assign out_valid   = (count != 3'd0);
  assign q           = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      rd_ptr <= rd_ptr + {1'b0, pop};
      wr_ptr <= wr_ptr + n_push[1:0];
      count  <= count_next;
    end
  end

  // Store up to two results per cycle
  always_ff @(posedge clk) begin
    if (n_push != 3'd0) begin
      mem[wr_ptr] <= d0;
    end
    if (ctl.push_two) begin
      mem[wr_ptr + 2'd1] <= d1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push_two |-> (count_after_pop <= 3'd2))
    else $error("two results pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + $past(n_push) - {2'b00, $past(pop)})
    else $error("result queue count out of step with traffic");

endmodule

FILE: rtl/core/turtle_command_interpreter.sv
// Timing: a command is registered at acceptance; its results enter the output
// queue once the queue has room for two results, and the queue head drives
// the output port.
// Throughput: one command per cycle while the queue has room for two results;
// a pen-down move marked last yields two results on the single output port.
// Reset (rst, synchronous): turtle at (0,0) facing east, pen down, black;
// canvas registers back to 512 x 512; command register and output queue emptied.
module turtle_command_interpreter #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic                         wr_index,
  input  logic [12:0]                  wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   action,
  input  logic signed [15:0]           value,
  input  logic                         last_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [COORD_BITS-1:0]        x_start,
  output logic [COORD_BITS-1:0]        y_start,
  output logic [COORD_BITS-1:0]        x_end,
  output logic [COORD_BITS-1:0]        y_end,
  output logic [7:0]                   grey_level,
  output logic                         run_last
);

  localparam int SW     = 18;
  localparam int RES_W  = 4 * COORD_BITS + 10;
  localparam logic [SW-1:0] CAP = SW'((1 << COORD_BITS) - 1);

  // Canvas registers
  logic [12:0] canvas_width;
  logic [12:0] canvas_height;

  // Command register
  logic               s1_valid;
  tci_pkg::action_t   s1_action;
  logic signed [15:0] s1_value;
  logic               s1_last;
  logic               s1_adv;

  // Turtle state
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  tci_pkg::head_t        heading;
  logic                  pen_down;
  logic [7:0]            draw_level;

  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  tci_pkg::head_t        heading_next;
  logic                  pen_down_next;
  logic [7:0]            draw_level_next;

  logic                  is_move;
  logic                  seg;
  logic signed [SW-1:0]  move_dist;
  logic signed [SW-1:0]  sum_x;
  logic signed [SW-1:0]  sum_y;
  logic [SW-1:0]         lim_x;
  logic [SW-1:0]         lim_y;
  logic [COORD_BITS-1:0] move_x;
  logic [COORD_BITS-1:0] move_y;

  tci_pkg::fifo_ctl_t    fctl;
  tci_pkg::fifo_stat_t   fstat;
  logic [RES_W-1:0]      res_seg;
  logic [RES_W-1:0]      res_fin;
  logic [RES_W-1:0]      d0;
  logic [RES_W-1:0]      d1;
  logic [RES_W-1:0]      q;

  // Largest coordinate for a canvas size, saturated to the coordinate width
  function automatic logic [SW-1:0] edge_of(input logic [12:0] size);
    logic [12:0]   lim13;
    logic [SW-1:0] lim;
    lim13 = (size == 13'd0) ? 13'd0 : size - 13'd1;
    lim   = {{(SW-13){1'b0}}, lim13};
    return (lim > CAP) ? CAP : lim;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_to(input logic signed [SW-1:0] v,
                                                      input logic [SW-1:0] lim);
    logic [SW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if ($unsigned(v) > lim) begin
      r = lim;
    end else begin
      r = $unsigned(v);
    end
    return r[COORD_BITS-1:0];
  endfunction

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= tci_pkg::CANVAS_RESET;
      canvas_height <= tci_pkg::CANVAS_RESET;
    end else if (wr_en) begin
      if (wr_index == tci_pkg::CFG_WIDTH) begin
        canvas_width <= wr_data;
      end else begin
        canvas_height <= wr_data;
      end
    end
  end

  // Hold a command until the queue has room for both of its results
  assign s1_adv   = s1_valid && fstat.room2;
  assign in_stall = s1_valid && !fstat.room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && !in_stall) || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= tci_pkg::action_t'(action);
      s1_value  <= value;
      s1_last   <= last_item;
    end
  end

  // Move arithmetic along the heading, then clamp to the canvas
  always_comb begin
    move_dist = {{(SW-16){s1_value[15]}}, s1_value};
    if (s1_action == tci_pkg::ACT_BACKWARD) begin
      move_dist = -move_dist;
    end
    sum_x = $signed({{(SW-COORD_BITS){1'b0}}, pos_x});
    sum_y = $signed({{(SW-COORD_BITS){1'b0}}, pos_y});
    case (heading)
      tci_pkg::HEAD_EAST:  sum_x = sum_x + move_dist;
      tci_pkg::HEAD_SOUTH: sum_y = sum_y + move_dist;
      tci_pkg::HEAD_WEST:  sum_x = sum_x - move_dist;
      default:             sum_y = sum_y - move_dist;
    endcase
    lim_x  = edge_of(canvas_width);
    lim_y  = edge_of(canvas_height);
    move_x = clamp_to(sum_x, lim_x);
    move_y = clamp_to(sum_y, lim_y);
  end

  // Next turtle state for the command in the register
  always_comb begin
    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    heading_next    = heading;
    pen_down_next   = pen_down;
    draw_level_next = draw_level;
    is_move         = 1'b0;
    case (s1_action)
      tci_pkg::ACT_PENUP:   pen_down_next = 1'b0;
      tci_pkg::ACT_PENDOWN: pen_down_next = 1'b1;
      tci_pkg::ACT_COLOUR: begin
        if (s1_value < 0) begin
          draw_level_next = 8'd0;
        end else if (s1_value > 16'sd255) begin
          draw_level_next = tci_pkg::LEVEL_MAX;
        end else begin
          draw_level_next = s1_value[7:0];
        end
      end
      tci_pkg::ACT_FORWARD, tci_pkg::ACT_BACKWARD: begin
        is_move    = 1'b1;
        pos_x_next = move_x;
        pos_y_next = move_y;
      end
      tci_pkg::ACT_RIGHT: heading_next = tci_pkg::head_t'(heading + 2'd1);
      tci_pkg::ACT_LEFT:  heading_next = tci_pkg::head_t'(heading + 2'd3);
      default: ;
    endcase
  end

  // Build results and the push request
  always_comb begin
    seg     = is_move && pen_down;
    res_seg = {tci_pkg::KIND_SEGMENT, pos_x, pos_y, pos_x_next, pos_y_next,
               draw_level, !s1_last};
    res_fin = {tci_pkg::KIND_FINAL, {COORD_BITS{1'b0}}, {COORD_BITS{1'b0}},
               pos_x_next, pos_y_next, 8'd0, 1'b1};
    d0      = seg ? res_seg : res_fin;
    d1      = res_fin;
    fctl.push_two = s1_adv && seg && s1_last;
    fctl.push_one = s1_adv && (seg || s1_last);
  end

  // Update turtle state; a last command returns the turtle home
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= tci_pkg::HEAD_EAST;
      pen_down   <= 1'b1;
      draw_level <= 8'd0;
    end else if (s1_adv) begin
      if (s1_last) begin
        pos_x      <= '0;
        pos_y      <= '0;
        heading    <= tci_pkg::HEAD_EAST;
        pen_down   <= 1'b1;
        draw_level <= 8'd0;
      end else begin
        pos_x      <= pos_x_next;
        pos_y      <= pos_y_next;
        heading    <= heading_next;
        pen_down   <= pen_down_next;
        draw_level <= draw_level_next;
      end
    end
  end

  tci_result_fifo #(
    .DATA_W (RES_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fctl),
    .d0        (d0),
    .d1        (d1),
    .stat      (fstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (q)
  );

  assign {kind, x_start, y_start, x_end, y_end, grey_level, run_last} = q;

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty command register");

  a_home_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_last) |=> (pos_x == '0 && pos_y == '0 &&
                             heading == tci_pkg::HEAD_EAST && pen_down))
    else $error("turtle not home after last command");

  a_move_in_canvas: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && is_move && !s1_last) |=>
      ({{(SW-COORD_BITS){1'b0}}, pos_x} <= $past(lim_x) &&
       {{(SW-COORD_BITS){1'b0}}, pos_y} <= $past(lim_y)))
    else $error("move left the canvas");

  a_seg_pushes: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && seg) |-> fctl.push_one)
    else $error("pen-down move produced no segment");

endmodule
